// ===== rtl/core/flfa_pkg.sv =====
// Shared types and constants of the free-list fit allocator.
package flfa_pkg;

    localparam int FLFA_ARENA_UNITS = 1024;

    localparam logic       KIND_ALLOC = 1'b0;
    localparam logic       KIND_FREE  = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BOUNDS = 2'd2;

    localparam logic [1:0] ADDR_FIT_MODE = 2'd0;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_A_LEN,
        S_A_LNK,
        S_A_END,
        S_A_NX,
        S_A_W2,
        S_A_W3,
        S_A_W4,
        S_F_CHK,
        S_F_HLEN,
        S_F_WALK,
        S_F_WLNK,
        S_F_DEC,
        S_F_CLNK,
        S_F_CLEN,
        S_F_WH,
        S_F_WH1,
        S_F_PCHK,
        S_F_PW2,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/flfa_mem.sv =====
// Arena word memory: one write port, one read port, registered read data.
module flfa_mem #(
    parameter int DEPTH = flfa_pkg::FLFA_ARENA_UNITS,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = AW + 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/flfa_ctrl.sv =====
// Sequencer that walks, splits and merges the free list held in the arena memory.
module flfa_ctrl #(
    parameter int ARENA_UNITS = flfa_pkg::FLFA_ARENA_UNITS,
    parameter int AW          = $clog2(ARENA_UNITS),
    parameter int DW          = AW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_fit_mode,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_kind,
    input  logic [9:0]    i_request_units,
    input  logic [9:0]    i_release_address,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_status,
    output logic [9:0]    o_grant_address,
    output logic [9:0]    o_grant_units,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [DW-1:0] o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [DW-1:0] i_rdata
);
    import flfa_pkg::*;

    localparam int            SW   = (DW > 11) ? DW : 11;
    localparam logic [DW-1:0] LAST = DW'(ARENA_UNITS - 1);
    localparam logic [DW-1:0] LEND = DW'(ARENA_UNITS);

    function automatic logic is_node(input logic [DW-1:0] x);
        return x < LAST;
    endfunction

    function automatic logic [DW-1:0] blen(input logic [DW-1:0] h, input logic [DW-1:0] d);
        logic [DW-1:0] room;
        room = LAST - h;
        return (d > room) ? room : d;
    endfunction

    function automatic logic [DW-1:0] nlink(input logic [DW-1:0] d);
        return is_node(d) ? d : LEND;
    endfunction

    function automatic logic [AW-1:0] adx(input logic [DW-1:0] x);
        return x[AW-1:0];
    endfunction

    function automatic logic [9:0] o10(input logic [DW-1:0] x);
        logic [SW-1:0] t;
        t = SW'(x);
        return t[9:0];
    endfunction

    t_state        r_state, n_state;
    logic [DW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_head, n_head;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_ost, n_ost;
    logic [9:0]    r_oga, n_oga;
    logic [9:0]    r_ogu, n_ogu;
    logic [1:0]    r_res_st, n_res_st;
    logic [9:0]    r_res_ga, n_res_ga;
    logic [9:0]    r_res_gu, n_res_gu;
    logic [SW-1:0] r_req, n_req;
    logic [9:0]    r_addr, n_addr;
    logic [1:0]    r_mode, n_mode;
    logic [DW-1:0] r_cur, n_cur;
    logic [DW-1:0] r_prev, n_prev;
    logic          r_has_prev, n_has_prev;
    logic [DW-1:0] r_steps, n_steps;
    logic          r_found, n_found;
    logic [DW-1:0] r_tgt, n_tgt;
    logic [DW-1:0] r_tlen, n_tlen;
    logic [DW-1:0] r_tprev, n_tprev;
    logic          r_thas, n_thas;
    logic [DW-1:0] r_follow, n_follow;
    logic [DW-1:0] r_link, n_link;
    logic [SW-1:0] r_grant, n_grant;
    logic [DW-1:0] r_h, n_h;
    logic [DW-1:0] r_s, n_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ost      <= n_ost;
        r_oga      <= n_oga;
        r_ogu      <= n_ogu;
        r_res_st   <= n_res_st;
        r_res_ga   <= n_res_ga;
        r_res_gu   <= n_res_gu;
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_mode     <= n_mode;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_has_prev <= n_has_prev;
        r_steps    <= n_steps;
        r_found    <= n_found;
        r_tgt      <= n_tgt;
        r_tlen     <= n_tlen;
        r_tprev    <= n_tprev;
        r_thas     <= n_thas;
        r_follow   <= n_follow;
        r_link     <= n_link;
        r_grant    <= n_grant;
        r_h        <= n_h;
        r_s        <= n_s;
    end

    always_comb begin
        logic [DW-1:0] l;
        logic [SW-1:0] diff;
        logic [SW-1:0] hs;
        logic          first;
        logic          take;
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_head     = r_head;
        n_ovalid   = r_ovalid;
        n_ost      = r_ost;
        n_oga      = r_oga;
        n_ogu      = r_ogu;
        n_res_st   = r_res_st;
        n_res_ga   = r_res_ga;
        n_res_gu   = r_res_gu;
        n_req      = r_req;
        n_addr     = r_addr;
        n_mode     = r_mode;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_has_prev = r_has_prev;
        n_steps    = r_steps;
        n_found    = r_found;
        n_tgt      = r_tgt;
        n_tlen     = r_tlen;
        n_tprev    = r_tprev;
        n_thas     = r_thas;
        n_follow   = r_follow;
        n_link     = r_link;
        n_grant    = r_grant;
        n_h        = r_h;
        n_s        = r_s;
        o_we       = 1'b0;
        o_waddr    = '0;
        o_wdata    = '0;
        o_raddr    = '0;
        l          = blen(r_cur, i_rdata);
        diff       = SW'(r_tlen) - r_req;
        hs         = SW'(r_addr) - SW'(1);
        first      = (r_mode != MODE_BEST) && (r_mode != MODE_WORST);
        take       = 1'b0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = adx(r_cnt);
                o_wdata = (r_cnt == '0) ? LAST : ((r_cnt == DW'(1)) ? LEND : '0);
                n_cnt   = r_cnt + DW'(1);
                if (r_cnt == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req      = (i_request_units == '0) ? SW'(1) : SW'(i_request_units);
                    n_addr     = i_release_address;
                    n_mode     = i_fit_mode;
                    n_cur      = is_node(r_head) ? r_head : LEND;
                    n_prev     = '0;
                    n_has_prev = 1'b0;
                    n_steps    = '0;
                    n_found    = 1'b0;
                    n_res_st   = ST_DONE;
                    n_res_ga   = '0;
                    n_res_gu   = '0;
                    n_state    = (i_kind == KIND_FREE) ? S_F_CHK : S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (is_node(r_cur) && r_steps < LEND) begin
                    o_raddr = adx(r_cur);
                    n_state = S_A_LEN;
                end else begin
                    n_state = S_A_END;
                end
            end
            S_A_LEN: begin
                if (SW'(l) >= r_req) begin
                    take = first
                        || (r_mode == MODE_BEST && (!r_found || l < r_tlen))
                        || (r_mode == MODE_WORST && (!r_found || l > r_tlen));
                end
                if (take) begin
                    n_found = 1'b1;
                    n_tgt   = r_cur;
                    n_tlen  = l;
                    n_tprev = r_prev;
                    n_thas  = r_has_prev;
                end
                if (first && SW'(l) >= r_req) begin
                    n_state = S_A_END;
                end else begin
                    o_raddr = adx(r_cur + DW'(1));
                    n_state = S_A_LNK;
                end
            end
            S_A_LNK: begin
                n_prev     = r_cur;
                n_has_prev = 1'b1;
                n_cur      = nlink(i_rdata);
                n_steps    = r_steps + DW'(1);
                n_state    = S_A_CHK;
            end
            S_A_END: begin
                if (!r_found) begin
                    n_res_st = ST_NOFIT;
                    n_state  = S_OUT;
                end else begin
                    o_raddr = adx(r_tgt + DW'(1));
                    n_state = S_A_NX;
                end
            end
            S_A_NX: begin
                if (diff >= SW'(2)) begin
                    n_grant  = r_req;
                    n_follow = DW'(SW'(r_tgt) + SW'(1) + r_req);
                    n_link   = nlink(i_rdata);
                    o_we     = 1'b1;
                    o_waddr  = adx(DW'(SW'(r_tgt) + SW'(1) + r_req));
                    o_wdata  = DW'(diff - SW'(1));
                    n_state  = S_A_W2;
                end else begin
                    n_grant  = SW'(r_tlen);
                    n_follow = nlink(i_rdata);
                    n_state  = S_A_W3;
                end
            end
            S_A_W2: begin
                o_we    = 1'b1;
                o_waddr = adx(r_follow + DW'(1));
                o_wdata = r_link;
                n_state = S_A_W3;
            end
            S_A_W3: begin
                if (r_thas) begin
                    o_we    = 1'b1;
                    o_waddr = adx(r_tprev + DW'(1));
                    o_wdata = r_follow;
                end else begin
                    n_head = r_follow;
                end
                n_state = S_A_W4;
            end
            S_A_W4: begin
                o_we     = 1'b1;
                o_waddr  = adx(r_tgt);
                o_wdata  = DW'(r_grant);
                n_res_st = ST_DONE;
                n_res_ga = o10(r_tgt + DW'(1));
                n_res_gu = r_grant[9:0];
                n_state  = S_OUT;
            end
            S_F_CHK: begin
                if (r_addr == '0 || hs >= SW'(ARENA_UNITS - 2)) begin
                    n_res_st = ST_BOUNDS;
                    n_state  = S_OUT;
                end else begin
                    n_h     = DW'(hs);
                    o_raddr = hs[AW-1:0];
                    n_state = S_F_HLEN;
                end
            end
            S_F_HLEN: begin
                n_s     = (blen(r_h, i_rdata) == '0) ? DW'(1) : blen(r_h, i_rdata);
                n_state = S_F_WALK;
            end
            S_F_WALK: begin
                if (is_node(r_cur) && r_cur <= r_h && r_steps < LEND) begin
                    o_raddr = adx(r_cur + DW'(1));
                    n_state = S_F_WLNK;
                end else begin
                    if (r_steps >= LEND) begin
                        n_cur = LEND;
                    end
                    n_state = S_F_DEC;
                end
            end
            S_F_WLNK: begin
                n_prev     = r_cur;
                n_has_prev = 1'b1;
                n_cur      = nlink(i_rdata);
                n_steps    = r_steps + DW'(1);
                n_state    = S_F_WALK;
            end
            S_F_DEC: begin
                if (r_has_prev && r_prev == r_h) begin
                    n_state = S_OUT;
                end else if (is_node(r_cur)
                             && SW'(r_h) + SW'(1) + SW'(r_s) == SW'(r_cur)) begin
                    o_raddr = adx(r_cur + DW'(1));
                    n_state = S_F_CLNK;
                end else begin
                    n_link  = r_cur;
                    n_state = S_F_WH;
                end
            end
            S_F_CLNK: begin
                n_link  = nlink(i_rdata);
                o_raddr = adx(r_cur);
                n_state = S_F_CLEN;
            end
            S_F_CLEN: begin
                n_s     = r_s + DW'(1) + l;
                n_state = S_F_WH;
            end
            S_F_WH: begin
                o_we    = 1'b1;
                o_waddr = adx(r_h);
                o_wdata = r_s;
                n_state = S_F_WH1;
            end
            S_F_WH1: begin
                o_we    = 1'b1;
                o_waddr = adx(r_h + DW'(1));
                o_wdata = r_link;
                if (!r_has_prev) begin
                    n_head  = r_h;
                    n_state = S_OUT;
                end else begin
                    o_raddr = adx(r_prev);
                    n_state = S_F_PCHK;
                end
            end
            S_F_PCHK: begin
                o_we = 1'b1;
                if (SW'(r_prev) + SW'(1) + SW'(blen(r_prev, i_rdata)) == SW'(r_h)) begin
                    o_waddr = adx(r_prev);
                    o_wdata = blen(r_prev, i_rdata) + DW'(1) + r_s;
                    n_state = S_F_PW2;
                end else begin
                    o_waddr = adx(r_prev + DW'(1));
                    o_wdata = r_h;
                    n_state = S_OUT;
                end
            end
            S_F_PW2: begin
                o_we    = 1'b1;
                o_waddr = adx(r_prev + DW'(1));
                o_wdata = r_link;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_oga    = r_res_ga;
                    n_ogu    = r_res_gu;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ost;
    assign o_grant_address = r_oga;
    assign o_grant_units   = r_ogu;
endmodule

// ===== rtl/core/free_list_fit_allocator.sv =====
// Top level of the free-list fit allocator: config register, sequencer and arena memory.
//
//   channel | valid       | stall       | words
//   in      | i_in_valid  | o_in_stall  | i_kind, i_request_units, i_release_address
//   out     | o_out_valid | i_out_stall | o_status, o_grant_address, o_grant_units
//   config  | psel/penable/pwrite | pready=1 | fit_mode at byte address 0
//
// An allocate reads length and link of each free block that it walks, a free only the link.
// After reset a clearing pass writes every arena word; no word is taken meanwhile.
// One word is in flight at a time; the result register holds while stalled and the next
// word may be taken while it waits.
module free_list_fit_allocator #(
    parameter int ARENA_UNITS = flfa_pkg::FLFA_ARENA_UNITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [9:0]  i_request_units,
    input  logic [9:0]  i_release_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [9:0]  o_grant_address,
    output logic [9:0]  o_grant_units
);
    import flfa_pkg::*;

    localparam int AW = $clog2(ARENA_UNITS);
    localparam int DW = AW + 1;

    logic [1:0]    r_fit_mode;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= MODE_FIRST;
        end else if (psel && penable && pwrite && paddr == ADDR_FIT_MODE) begin
            r_fit_mode <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FIT_MODE) ? {30'd0, r_fit_mode} : 32'd0;

    flfa_ctrl #(
        .ARENA_UNITS(ARENA_UNITS),
        .AW(AW),
        .DW(DW)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_fit_mode(r_fit_mode),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_request_units(i_request_units),
        .i_release_address(i_release_address),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_grant_address(o_grant_address),
        .o_grant_units(o_grant_units),
        .o_we(we),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_raddr(raddr),
        .i_rdata(rdata)
    );

    flfa_mem #(
        .DEPTH(ARENA_UNITS),
        .AW(AW),
        .DW(DW)
    ) u_mem (
        .i_clk(i_clk),
        .i_we(we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );
endmodule

// ===== rtl/core/flfa_chk.sv =====
// Port-level checks of the allocator, bound to the top level.
module flfa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [9:0]  o_grant_address,
    input logic [9:0]  o_grant_units
);
    import flfa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_grant_address == '0 && o_grant_units == '0)
        else $error("failed request carries a grant");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_DONE || o_status == ST_NOFIT || o_status == ST_BOUNDS)
        else $error("status code out of range");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");
endmodule

bind free_list_fit_allocator flfa_chk u_flfa_chk (.*);

// ===== tb/tb_free_list_fit_allocator.sv =====
// Testbench of the free-list fit allocator: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_free_list_fit_allocator;
    import flfa_pkg::*;

    localparam int          UNITS      = FLFA_ARENA_UNITS;
    localparam int unsigned LINK_END   = UNITS;
    localparam logic [1:0]  MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] addr;
        logic [9:0] units;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = KIND_ALLOC;
    logic [9:0]  i_request_units = '0;
    logic [9:0]  i_release_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [9:0]  o_grant_address;
    logic [9:0]  o_grant_units;

    free_list_fit_allocator dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned heap [UNITS];
    int unsigned head;
    logic [1:0]  policy;

    t_result     pending_results[$];
    logic [9:0]  live_blocks[$];
    logic [9:0]  freed_blocks[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    function automatic bit is_node(int unsigned h);
        return h < UNITS - 1;
    endfunction

    function automatic int unsigned len_at(int unsigned h);
        int unsigned room;
        room = UNITS - 1 - h;
        return heap[h] > room ? room : heap[h];
    endfunction

    function automatic int unsigned link_at(int unsigned h);
        return is_node(heap[h + 1]) ? heap[h + 1] : LINK_END;
    endfunction

    function automatic t_result predict_alloc(int unsigned req);
        int unsigned cur, prev, steps, tgt, tgt_prev, tgt_len, nxt, grant, follow, l;
        bit has_prev, found, tgt_has_prev, take, first;
        t_result r;
        cur = head; prev = 0; steps = 0; has_prev = 0; found = 0;
        tgt = 0; tgt_prev = 0; tgt_len = 0; tgt_has_prev = 0;
        first = (policy == MODE_FIRST) || (policy == MODE_SPARE);
        if (req == 0) req = 1;
        while (is_node(cur) && steps < UNITS) begin
            l = len_at(cur);
            if (l >= req) begin
                take = first || (policy == MODE_BEST && (!found || l < tgt_len))
                       || (policy == MODE_WORST && (!found || l > tgt_len));
                if (take) begin
                    found = 1; tgt = cur; tgt_len = l;
                    tgt_prev = prev; tgt_has_prev = has_prev;
                end
                if (first) break;
            end
            prev = cur; has_prev = 1; cur = link_at(cur); steps++;
        end
        if (!found) return '{ST_NOFIT, 10'd0, 10'd0};
        nxt = link_at(tgt);
        grant = req;
        if (tgt_len - req < 2) begin
            grant = tgt_len;
            follow = nxt;
        end else begin
            follow = tgt + 1 + req;
            heap[follow] = tgt_len - req - 1;
            heap[follow + 1] = nxt;
        end
        if (tgt_has_prev) heap[tgt_prev + 1] = follow;
        else head = follow;
        heap[tgt] = grant;
        r.status = ST_DONE;
        r.addr = 10'(tgt + 1);
        r.units = 10'(grant);
        return r;
    endfunction

    function automatic t_result predict_free(int unsigned addr);
        int unsigned h, s, cur, prev, steps, link, pl;
        bit has_prev;
        if (addr == 0 || addr - 1 > UNITS - 3) return '{ST_BOUNDS, 10'd0, 10'd0};
        h = addr - 1;
        s = len_at(h);
        if (s == 0) s = 1;
        prev = 0; steps = 0; has_prev = 0;
        cur = is_node(head) ? head : LINK_END;
        while (is_node(cur) && cur <= h && steps < UNITS) begin
            prev = cur; has_prev = 1; cur = link_at(cur); steps++;
        end
        if (steps >= UNITS) cur = LINK_END;
        if (has_prev && prev == h) return '{ST_DONE, 10'd0, 10'd0};
        if (is_node(cur) && h + 1 + s == cur) begin
            link = link_at(cur);
            s = s + 1 + len_at(cur);
        end else begin
            link = cur;
        end
        heap[h] = s;
        heap[h + 1] = link;
        if (!has_prev) begin
            head = h;
        end else begin
            pl = len_at(prev);
            if (prev + 1 + pl == h) begin
                heap[prev] = pl + 1 + s;
                heap[prev + 1] = link;
            end else begin
                heap[prev + 1] = h;
            end
        end
        return '{ST_DONE, 10'd0, 10'd0};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // one word, accepted at a posedge; valid stays high until an idle gap
    task automatic send_word(logic kind, logic [9:0] req, logic [9:0] addr);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind = kind;
        i_request_units = req;
        i_release_address = addr;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (kind == KIND_ALLOC) begin
            r = predict_alloc(req);
            if (r.status == ST_DONE) live_blocks.push_back(r.addr);
        end else begin
            r = predict_free(addr);
        end
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_policy(logic [1:0] mode);
        drain();
        psel = 1'b1; pwrite = 1'b1; paddr = ADDR_FIT_MODE; pwdata = 32'(mode);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        policy = mode;
    endtask

    task automatic send_random();
        int pick, idx;
        logic [9:0] a;
        pick = $urandom_range(99);
        if (pick < 50 || live_blocks.size() == 0) begin
            if ($urandom_range(19) == 0) send_word(KIND_ALLOC, 10'($urandom), 10'($urandom));
            else send_word(KIND_ALLOC, 10'($urandom_range(0, 60)), 10'($urandom));
        end else if (pick < 92) begin
            idx = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[idx];
            live_blocks.delete(idx);
            freed_blocks.push_back(a);
            if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
            send_word(KIND_FREE, 10'($urandom), a);
        end else if (pick < 96 && freed_blocks.size() != 0) begin
            send_word(KIND_FREE, 10'($urandom),
                      freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
        end else if (pick < 98) begin
            send_word(KIND_FREE, 10'($urandom), 10'($urandom_range(1022, 1023)));
        end else begin
            send_word(KIND_FREE, 10'($urandom), 10'($urandom));
        end
    endtask

    task automatic test_directed();
        send_word(KIND_ALLOC, 10'd0, 10'd0);
        send_word(KIND_ALLOC, 10'd1, 10'd1023);
        send_word(KIND_ALLOC, 10'd1023, 10'd0);
        send_word(KIND_FREE, 10'd1023, 10'd0);
        send_word(KIND_FREE, 10'd0, 10'd1023);
        send_word(KIND_FREE, 10'd0, 10'd1022);
        send_word(KIND_ALLOC, 10'd5, 10'd0);
        send_word(KIND_ALLOC, 10'd7, 10'd0);
        send_word(KIND_FREE, 10'd0, 10'd2);
        send_word(KIND_FREE, 10'd0, 10'd2);
        send_word(KIND_FREE, 10'd0, 10'd500);
        send_word(KIND_ALLOC, 10'd1, 10'd0);
        send_word(KIND_FREE, 10'd0, 10'd5);
        send_word(KIND_FREE, 10'd0, 10'd11);
        live_blocks.delete();
        send_word(KIND_ALLOC, 10'd1000, 10'd0);
        send_word(KIND_ALLOC, 10'd1020, 10'd0);
    endtask

    task automatic test_policies();
        logic [1:0] modes[4] = '{MODE_BEST, MODE_WORST, MODE_SPARE, MODE_FIRST};
        foreach (modes[m]) begin
            set_policy(modes[m]);
            repeat (250) send_random();
        end
    endtask

    task automatic test_backpressure();
        set_policy(MODE_BEST);
        hold_cycles = 400;
        repeat (30) send_random();
        drain();
        repeat (20) send_random();
    endtask

    task automatic test_random(int n);
        repeat (n) send_random();
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word status", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_grant_address !== want.addr)
                    report_mismatch("grant_address", o_grant_address, want.addr);
                if (o_grant_units !== want.units)
                    report_mismatch("grant_units", o_grant_units, want.units);
            end
        end
    end

    initial begin
        foreach (heap[i]) heap[i] = 0;
        heap[0] = UNITS - 1;
        heap[1] = LINK_END;
        head = 0;
        policy = MODE_FIRST;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        set_policy(MODE_FIRST);
        send_idle_pct = 10; recv_stall_pct = 61;
        test_directed();
        test_policies();
        send_idle_pct = 61; recv_stall_pct = 10;
        test_backpressure();
        set_policy(MODE_WORST);
        test_random(250);
        send_idle_pct = 0; recv_stall_pct = 0;
        set_policy(MODE_FIRST);
        test_random(250);
        drain();
        if (errors == 0)
            $display("free_list_fit_allocator: match");
        else
            $display("free_list_fit_allocator: mismatch");
        $finish;
    end

    initial begin
        #200ms;
        $display("free_list_fit_allocator: mismatch");
        $finish;
    end

endmodule
